[src/hufd_pkg.sv]
// Shared types, constants and helpers for the Huffman tree bit decoder.
// No dependencies; every other file of the block but hufd_ram imports this package.
`timescale 1ns / 1ps

package hufd_pkg;

  // Node memory geometry.
  localparam int MAX_NODES = 512;
  localparam int NODE_AW   = $clog2(MAX_NODES);

  // Field widths fixed by the transaction format.
  localparam int IDX_W    = 9;
  localparam int SYM_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  // Stream characters.
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'h31;

  // Commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DECODED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ROOT_NODE = 1'b0;

  // One tree node as stored in the node memory.
  typedef struct packed {
    logic [IDX_W-1:0] zero_child;
    logic             zero_present;
    logic [IDX_W-1:0] one_child;
    logic             one_present;
    logic             is_leaf;
    logic [SYM_W-1:0] leaf_symbol;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_CUR,
    S_RD_CHILD,
    S_EMIT
  } state_t;

  // Memory address of a node index, extended or truncated to the address width.
  function automatic logic [NODE_AW-1:0] node_addr(logic [IDX_W-1:0] idx);
    logic [IDX_W+NODE_AW-1:0] wide;
    wide = {{NODE_AW{1'b0}}, idx};
    return wide[NODE_AW-1:0];
  endfunction

  // True when the node index lies inside the node memory.
  function automatic logic node_in_range(logic [IDX_W-1:0] idx);
    logic [IDX_W+NODE_AW-1:0] wide;
    wide = {{NODE_AW{1'b0}}, idx};
    return wide < (IDX_W + NODE_AW)'(MAX_NODES);
  endfunction

endpackage

[src/hufd_in_if.sv]
// Input channel of the Huffman tree bit decoder: valid/ready plus one command.
// Depends on hufd_pkg for the field widths.
`timescale 1ns / 1ps

interface hufd_in_if import hufd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [IDX_W-1:0]  node_index;
  logic [IDX_W-1:0]  zero_child;
  logic              zero_present;
  logic [IDX_W-1:0]  one_child;
  logic              one_present;
  logic              is_leaf;
  logic [SYM_W-1:0]  leaf_symbol;
  logic [CHAR_W-1:0] in_char;

  modport source (
    output valid, command, node_index, zero_child, zero_present,
           one_child, one_present, is_leaf, leaf_symbol, in_char,
    input  ready
  );

  modport sink (
    input  valid, command, node_index, zero_child, zero_present,
           one_child, one_present, is_leaf, leaf_symbol, in_char,
    output ready
  );
endinterface

[src/hufd_out_if.sv]
// Result channel of the Huffman tree bit decoder: valid/ready plus status and symbol.
// Depends on hufd_pkg for the field widths.
`timescale 1ns / 1ps

interface hufd_out_if import hufd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SYM_W-1:0]    symbol;

  modport source (output valid, status, symbol, input ready);
  modport sink   (input valid, status, symbol, output ready);
endinterface

[src/hufd_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/huffman_tree_bit_decoder.sv]
// Huffman tree bit decoder: walks a code tree kept in a node RAM, one bit per decode.
// A non-binary character's result is registered straight from idle. A binary character
// reads its current node, then the chosen child: a missing child is an invalid code, a
// leaf child gives its symbol. A load writes its node at the accept edge. Input is taken
// only in idle; node reads hold it, as does a result that finds the output full.
// Reset: control state, root_node and walk position return to node 0; RAM is not cleared.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder import hufd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  hufd_in_if.sink            in_ch,
  hufd_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    root_r, root_nxt;
  logic [IDX_W-1:0]    cur_node_r, cur_node_nxt;
  logic [IDX_W-1:0]    child_r, child_nxt;
  logic                bit_r, bit_nxt;
  logic                oor_r, oor_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SYM_W-1:0]    out_symbol_r, out_symbol_nxt;
  logic [STATUS_W-1:0] pend_status_r, pend_status_nxt;
  logic [SYM_W-1:0]    pend_symbol_r, pend_symbol_nxt;

  // ---------------------------------------------------------------------------
  // Node RAM
  // ---------------------------------------------------------------------------
  logic               ram_we;
  logic [NODE_AW-1:0] ram_waddr;
  node_t              ram_wdata;
  logic               ram_re;
  logic [NODE_AW-1:0] ram_raddr;
  logic [NODE_W-1:0]  ram_rdata;
  node_t              rd_node;

  hufd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A node index outside the memory reads as an empty, non-leaf node.
  assign rd_node = oor_r ? '0 : node_t'(ram_rdata);

  // ---------------------------------------------------------------------------
  // Handshake decode
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic in_is_bin;
  logic out_free;
  logic cfg_wr;

  // Only one transaction is in flight; a new one is taken once the walk step
  // has finished, even while the previous result still sits in the output register.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_is_bin   = (in_ch.in_char == CHAR_ZERO) || (in_ch.in_char == CHAR_ONE);
  assign out_free    = !out_valid_r || out_ch.ready;

  // APB: always ready, register 0 sits at byte address 0, address bit 2 selects
  // registers beyond the list, which read as zero and ignore writes.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ROOT_NODE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ROOT_NODE) begin
      prdata = {{(DATA_W - IDX_W){1'b0}}, root_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Walk datapath: memory accesses, result generation and the walk position.
  // ---------------------------------------------------------------------------
  logic                sel_present;
  logic [IDX_W-1:0]    sel_child;
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [SYM_W-1:0]    res_symbol;
  logic                step_done;

  assign sel_present = bit_r ? rd_node.one_present : rd_node.zero_present;
  assign sel_child   = bit_r ? rd_node.one_child   : rd_node.zero_child;

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = node_addr(in_ch.node_index);
    ram_wdata    = '{zero_child:   in_ch.zero_child,
                     zero_present: in_ch.zero_present,
                     one_child:    in_ch.one_child,
                     one_present:  in_ch.one_present,
                     is_leaf:      in_ch.is_leaf,
                     leaf_symbol:  in_ch.leaf_symbol};
    ram_re       = 1'b0;
    ram_raddr    = node_addr(cur_node_r);
    oor_nxt      = oor_r;
    bit_nxt      = bit_r;
    child_nxt    = child_r;
    cur_node_nxt = cur_node_r;
    root_nxt     = root_r;
    res_valid    = 1'b0;
    res_status   = STATUS_DECODED;
    res_symbol   = '0;
    step_done    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.command == CMD_LOAD)) begin
          // Loads beyond the memory are dropped.
          ram_we = node_in_range(in_ch.node_index);
        end else if (in_acc && in_is_bin) begin
          // Fetch the node the walk stands on.
          ram_re  = 1'b1;
          oor_nxt = !node_in_range(cur_node_r);
          bit_nxt = in_ch.in_char[0];
        end else if (in_acc) begin
          // Non-binary character: warn, keep the walk position.
          res_valid  = 1'b1;
          res_status = STATUS_IGNORED;
        end
      end
      S_RD_CUR: begin
        if (!sel_present) begin
          res_valid    = 1'b1;
          res_status   = STATUS_INVALID;
          cur_node_nxt = root_r;
        end else begin
          // Fetch the chosen child to test its leaf flag.
          ram_re    = 1'b1;
          ram_raddr = node_addr(sel_child);
          oor_nxt   = !node_in_range(sel_child);
          child_nxt = sel_child;
        end
      end
      S_RD_CHILD: begin
        if (rd_node.is_leaf) begin
          res_valid    = 1'b1;
          res_status   = STATUS_DECODED;
          res_symbol   = rd_node.leaf_symbol;
          cur_node_nxt = root_r;
        end else begin
          cur_node_nxt = child_r;
          step_done    = 1'b1;
        end
      end
      S_EMIT: begin
        res_valid  = 1'b1;
        res_status = pend_status_r;
        res_symbol = pend_symbol_r;
      end
      default: begin
      end
    endcase

    // Writing the root also restarts the walk there.
    if (cfg_wr) begin
      root_nxt     = pwdata[IDX_W-1:0];
      cur_node_nxt = pwdata[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and pending-result stash. A result goes straight into the
  // output register when it is free; otherwise it waits in the stash.
  // ---------------------------------------------------------------------------
  logic out_load;
  logic pend_load;

  assign out_load  = res_valid && out_free;
  assign pend_load = res_valid && !out_free;

  always_comb begin
    out_valid_nxt   = out_load || (out_valid_r && !out_ch.ready);
    out_status_nxt  = out_load ? res_status : out_status_r;
    out_symbol_nxt  = out_load ? res_symbol : out_symbol_r;
    pend_status_nxt = pend_load ? res_status : pend_status_r;
    pend_symbol_nxt = pend_load ? res_symbol : pend_symbol_r;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.symbol = out_symbol_r;

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    priority if (out_load) begin
      state_nxt = S_IDLE;
    end else if (pend_load) begin
      state_nxt = S_EMIT;
    end else if (step_done) begin
      state_nxt = S_IDLE;
    end else if ((state_r == S_IDLE) && in_acc && (in_ch.command == CMD_DECODE)) begin
      state_nxt = S_RD_CUR;
    end else if (state_r == S_RD_CUR) begin
      state_nxt = S_RD_CHILD;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequential logic
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      root_r      <= '0;
      cur_node_r  <= '0;
      oor_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      root_r      <= root_nxt;
      cur_node_r  <= cur_node_nxt;
      oor_r       <= oor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    child_r       <= child_nxt;
    bit_r         <= bit_nxt;
    out_status_r  <= out_status_nxt;
    out_symbol_r  <= out_symbol_nxt;
    pend_status_r <= pend_status_nxt;
    pend_symbol_r <= pend_symbol_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_bin_decode_reads : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.command == CMD_DECODE) && in_is_bin) |=> (state_r == S_RD_CUR))
    else $error("binary decode did not start a node read");

  a_write_in_idle : assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("node RAM written outside idle");

  a_emit_waits_on_full : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> out_valid_r)
    else $error("stashed result held while output register is free");

  a_child_after_cur : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_CHILD) |-> ($past(state_r) == S_RD_CUR))
    else $error("child read without a current node read");

  a_no_read_write_clash : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("node RAM read and write in the same cycle");

endmodule

[tb/tb_huffman_tree_bit_decoder.sv]
// Self-checking testbench for huffman_tree_bit_decoder: loads code trees, streams
// characters and checks every result against a tree-walk predictor or a typed row.
// Depends on hufd_pkg, hufd_in_if, hufd_out_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_huffman_tree_bit_decoder;
  import hufd_pkg::*;

  // Run length and pacing knobs.
  localparam int ITEMS_TARGET  = 1850;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  // The root register is register 0 of the configuration map.
  localparam logic [PADDR_W-1:0] ROOT_ADDR = PADDR_W'(4 * REG_ROOT_NODE);

  // One result transaction as the decoder presents it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0]    symbol;
  } outcome_t;

  // One input transaction plus an optional hand-typed result for directed rows.
  typedef struct packed {
    logic              command;
    logic [IDX_W-1:0]  node_index;
    node_t             node;
    logic [CHAR_W-1:0] in_char;
    logic              typed;
    outcome_t          want;
  } walk_item_t;

  logic clk;
  logic rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  hufd_in_if  in_ch ();
  hufd_out_if out_ch ();

  huffman_tree_bit_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: its own copy of the node memory, the walk position and
  // the root register.
  node_t            node_mem [MAX_NODES];
  logic [IDX_W-1:0] walk_pos;
  logic [IDX_W-1:0] root_reg;

  // Results the decoder still owes, oldest first.
  outcome_t   outcome_q [$];
  walk_item_t cur_item;

  int idle_pct;
  int stall_pct;
  int hold_len;
  int hold_left;
  int fail_count;
  int sent_count;
  int cycles;

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a result that never comes ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Advances the predicted tree walk by one accepted transaction. Returns 1 when
  // the transaction causes a result, which is then left in res.
  function automatic logic tree_step(input walk_item_t it, output outcome_t res);
    node_t            here;
    node_t            there;
    logic             take_one;
    logic [IDX_W-1:0] next;
    res = '0;
    if (it.command == CMD_LOAD) begin
      node_mem[it.node_index] = it.node;
      return 1'b0;
    end
    // Anything other than '0' or '1' is reported and leaves the walk where it is.
    if (it.in_char != CHAR_ZERO && it.in_char != CHAR_ONE) begin
      res.status = STATUS_IGNORED;
      return 1'b1;
    end
    take_one = (it.in_char == CHAR_ONE);
    here = node_mem[walk_pos];
    // A missing child is an invalid code; the walk starts over at the root.
    if (take_one ? !here.one_present : !here.zero_present) begin
      walk_pos   = root_reg;
      res.status = STATUS_INVALID;
      return 1'b1;
    end
    next  = take_one ? here.one_child : here.zero_child;
    there = node_mem[next];
    // Only the child reached is tested for the leaf flag, never the node we left.
    if (there.is_leaf) begin
      walk_pos   = root_reg;
      res.status = STATUS_DECODED;
      res.symbol = there.leaf_symbol;
      return 1'b1;
    end
    walk_pos = next;
    return 1'b0;
  endfunction

  function automatic node_t rand_node();
    logic [NODE_W-1:0] raw;
    raw = NODE_W'($urandom());
    return node_t'(raw);
  endfunction

  function automatic node_t mk_node(input logic [IDX_W-1:0] zc, input logic zp,
                                    input logic [IDX_W-1:0] oc, input logic op,
                                    input logic leaf, input logic [SYM_W-1:0] sym);
    return '{zc, zp, oc, op, leaf, sym};
  endfunction

  // Fields that the command does not use carry random values.
  function automatic walk_item_t load_item(input logic [IDX_W-1:0] idx, input node_t n);
    walk_item_t it;
    it            = '0;
    it.command    = CMD_LOAD;
    it.node_index = idx;
    it.node       = n;
    it.in_char    = CHAR_W'($urandom());
    return it;
  endfunction

  function automatic walk_item_t char_item(input logic [CHAR_W-1:0] ch);
    walk_item_t it;
    it            = '0;
    it.command    = CMD_DECODE;
    it.node_index = IDX_W'($urandom());
    it.node       = rand_node();
    it.in_char    = ch;
    return it;
  endfunction

  function automatic walk_item_t typed_char(input logic [CHAR_W-1:0] ch,
                                            input logic [STATUS_W-1:0] st,
                                            input logic [SYM_W-1:0] sym);
    walk_item_t it;
    it             = char_item(ch);
    it.typed       = 1'b1;
    it.want.status = st;
    it.want.symbol = sym;
    return it;
  endfunction

  // Monitor. Both sides are sampled at the rising edge, before the decoder's
  // registers move. An accepted input transaction updates the predictor and
  // may queue a result; an accepted result transaction is checked against the
  // oldest queued one, field by field.
  always @(posedge clk) begin : watch
    outcome_t pred;
    outcome_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (tree_step(cur_item, pred)) begin
          outcome_q.push_back(cur_item.typed ? cur_item.want : pred);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: status %0d symbol %02h",
                                  out_ch.status, out_ch.symbol));
        end else begin
          want = outcome_q.pop_front();
          if (out_ch.status !== want.status) begin
            flag_mismatch($sformatf("status %0d, predicted %0d",
                                    out_ch.status, want.status));
          end
          if (out_ch.symbol !== want.symbol) begin
            flag_mismatch($sformatf("symbol %02h, predicted %02h",
                                    out_ch.symbol, want.symbol));
          end
        end
      end
    end
  end

  // Receiver pacing. A requested hold-off is counted out here, independent of
  // the sender, so the sender keeps offering transactions while results back up.
  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one input transaction and returns at the falling edge after it was
  // accepted. Valid stays high, so back-to-back transactions leave no bubble
  // unless the idle draw inserts one.
  task automatic send_item(input walk_item_t it);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cur_item              = it;
    in_ch.valid          <= 1'b1;
    in_ch.command        <= it.command;
    in_ch.node_index     <= it.node_index;
    in_ch.zero_child     <= it.node.zero_child;
    in_ch.zero_present   <= it.node.zero_present;
    in_ch.one_child      <= it.node.one_child;
    in_ch.one_present    <= it.node.one_present;
    in_ch.is_leaf        <= it.node.is_leaf;
    in_ch.leaf_symbol    <= it.node.leaf_symbol;
    in_ch.in_char        <= it.in_char;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    sent_count++;
  endtask

  // Stops sending, waits for every owed result, then lets the decoder finish
  // any intermediate step that produces no result.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the root register (upper data bits random, they must be dropped),
  // then reads it back. A root write also restarts the walk at the new root.
  task automatic write_root(input logic [IDX_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_ADDR;
    pwdata  <= (DATA_W'($urandom()) << IDX_W) | DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    root_reg = v;
    walk_pos = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[IDX_W-1:0] !== v) begin
      flag_mismatch($sformatf("root_node reads %0d, written %0d", prdata[IDX_W-1:0], v));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Builds a random full code tree under the given root and loads it. Chain
  // trees keep splitting the newest leaves, which gives long code words. In a
  // broken tree some inner nodes lose a child, so walks can hit invalid codes.
  task automatic load_tree(input logic [IDX_W-1:0] top, input int nleaves,
                           input bit chain, input bit broken);
    logic [MAX_NODES-1:0] taken;
    int unsigned          leaves [$];
    int unsigned          inner [$];
    logic [IDX_W-1:0]     zkid [MAX_NODES];
    logic [IDX_W-1:0]     okid [MAX_NODES];
    int unsigned          kid [2];
    int                   pick;
    int                   k;
    int                   j;
    node_t                n;
    taken      = '0;
    taken[top] = 1'b1;
    leaves.push_back(top);
    for (k = 1; k < nleaves; k++) begin
      pick = chain ? leaves.size() - 1 - $urandom_range(0, leaves.size() > 1 ? 1 : 0)
                   : $urandom_range(0, leaves.size() - 1);
      inner.push_back(leaves[pick]);
      leaves.delete(pick);
      for (j = 0; j < 2; j++) begin
        do kid[j] = $urandom_range(0, MAX_NODES - 1); while (taken[kid[j]]);
        taken[kid[j]] = 1'b1;
        leaves.push_back(kid[j]);
      end
      zkid[inner[$]] = IDX_W'(kid[0]);
      okid[inner[$]] = IDX_W'(kid[1]);
    end
    foreach (inner[i]) begin
      n              = rand_node();
      n.zero_child   = zkid[inner[i]];
      n.one_child    = okid[inner[i]];
      n.zero_present = 1'b1;
      n.one_present  = 1'b1;
      if (broken && $urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) != 0) n.zero_present = 1'b0;
        else n.one_present = 1'b0;
      end
      // The leaf flag of the root itself is never looked at, so it is random.
      n.is_leaf = (inner[i] == top) ? n.is_leaf : 1'b0;
      send_item(load_item(IDX_W'(inner[i]), n));
    end
    foreach (leaves[i]) begin
      n         = rand_node();
      n.is_leaf = 1'b1;
      send_item(load_item(IDX_W'(leaves[i]), n));
    end
  endtask

  initial begin : stimulus
    walk_item_t       rows [$];
    int               p;
    int               k;
    int               nch;
    int               r;
    logic [IDX_W-1:0] top;
    logic [CHAR_W-1:0] c;
    int               idle_mode [4];
    int               stall_mode [4];

    // Every input is known from time zero; reset starts asserted.
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_LOAD;
    in_ch.node_index   = '0;
    in_ch.zero_child   = '0;
    in_ch.zero_present = 1'b0;
    in_ch.one_child    = '0;
    in_ch.one_present  = 1'b0;
    in_ch.is_leaf      = 1'b0;
    in_ch.leaf_symbol  = '0;
    in_ch.in_char      = '0;
    out_ch.ready       = 1'b0;
    idle_pct           = 0;
    stall_pct          = 0;
    hold_len           = 0;
    hold_left          = 0;
    fail_count         = 0;
    sent_count         = 0;
    cycles             = 0;
    root_reg           = '0;
    walk_pos           = '0;
    idle_mode          = '{0, 64, 0, 28};
    stall_mode         = '{0, 0, 64, 28};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with the root at its reset value of node 0. Node 0 is
    // itself flagged as a leaf, which must not matter. Its one-child is the
    // last node of memory, a leaf with symbol FF; its zero-child leads through
    // node 1 (zero-child only) to node 2, a leaf with symbol 00.
    rows.push_back(load_item(9'd0, mk_node(9'd1, 1'b1, 9'd511, 1'b1, 1'b1, 8'hAA)));
    rows.push_back(load_item(9'd1, mk_node(9'd2, 1'b1, 9'd0, 1'b0, 1'b0, 8'h00)));
    rows.push_back(load_item(9'd2, mk_node(9'd511, 1'b1, 9'd511, 1'b1, 1'b1, 8'h00)));
    rows.push_back(load_item(9'd511, mk_node(9'd0, 1'b0, 9'd0, 1'b0, 1'b1, 8'hFF)));
    rows.push_back(typed_char(CHAR_ONE, STATUS_DECODED, 8'hFF));
    rows.push_back(typed_char(8'h00, STATUS_IGNORED, 8'h00));
    rows.push_back(typed_char(8'hFF, STATUS_IGNORED, 8'h00));
    // Intermediate step into node 1: no result.
    rows.push_back(char_item(CHAR_ZERO));
    // A stray character in mid-code keeps the walk on node 1.
    rows.push_back(typed_char(8'h41, STATUS_IGNORED, 8'h00));
    // Node 1 has no one-child: invalid code, back to the root.
    rows.push_back(typed_char(CHAR_ONE, STATUS_INVALID, 8'h00));
    rows.push_back(char_item(CHAR_ZERO));
    rows.push_back(typed_char(CHAR_ZERO, STATUS_DECODED, 8'h00));
    // Neighbors of the two binary characters.
    rows.push_back(typed_char(8'h2F, STATUS_IGNORED, 8'h00));
    rows.push_back(typed_char(8'h32, STATUS_IGNORED, 8'h00));
    rows.push_back(char_item(CHAR_ONE));
    // Loads with every field at its top and at its bottom value.
    rows.push_back(load_item(9'd3, mk_node(9'd511, 1'b1, 9'd511, 1'b1, 1'b1, 8'hFF)));
    rows.push_back(load_item(9'd4, mk_node(9'd0, 1'b0, 9'd0, 1'b0, 1'b0, 8'h00)));
    // Step into node 1 again; the root write below must pull the walk back.
    rows.push_back(char_item(CHAR_ZERO));
    foreach (rows[i]) send_item(rows[i]);
    settle();
    write_root(9'd0);
    send_item(char_item(CHAR_ONE));

    // Fill the whole node memory so that no walk can ever read a node that
    // was never written.
    for (k = 0; k < MAX_NODES; k++) send_item(load_item(IDX_W'(k), rand_node()));
    settle();

    // Random phases. Each one picks a pacing mode and a root, loads a fresh
    // tree and streams mostly well-formed bits, with stray characters and
    // stray node loads mixed in. The sender drains completely between phases.
    p = 0;
    while (sent_count < ITEMS_TARGET) begin
      idle_pct  = idle_mode[p % 4];
      stall_pct = stall_mode[p % 4];
      case (p % 5)
        1: top = 9'd511;
        3: top = 9'd0;
        default: top = IDX_W'($urandom_range(0, MAX_NODES - 1));
      endcase
      write_root(top);
      load_tree(top, $urandom_range(2, 24), $urandom_range(0, 2) == 0, p % 3 == 2);
      // Long receiver hold-off: the decoder fills up and must stall its input.
      if (p % 4 == 2) hold_len = HOLD_CYCLES;
      nch = $urandom_range(60, 140);
      for (k = 0; k < nch; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          do c = CHAR_W'($urandom_range(0, 255)); while (c == CHAR_ZERO || c == CHAR_ONE);
          send_item(char_item(c));
        end else if (r < 10) begin
          send_item(load_item(IDX_W'($urandom_range(0, MAX_NODES - 1)), rand_node()));
        end else begin
          send_item(char_item($urandom_range(0, 1) != 0 ? CHAR_ONE : CHAR_ZERO));
        end
      end
      settle();
      p++;
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
